/* src/prd_pkg.sv */
// Shared types and constants for the PCX run-length/delta decoder.
`default_nettype none
package prd_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 11;
    localparam int HGT_W     = 16;
    localparam int TOT_W     = WID_W + HGT_W;
    localparam int PIX_W     = 26;
    localparam int PAL_BYTES = 768;
    localparam int PAL_W     = 10;
    localparam int CNT_W     = 6;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_DELTA = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [1:0]       MODE_RESET   = 2'd1;
    localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd320;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 16'd200;

    localparam logic [7:0] RUN_MARK = 8'hC0;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_PAL   = 1'b1;

    typedef enum logic [1:0] {
        PH_IMAGE,
        PH_SEP,
        PH_PAL,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic             kind;
        logic [7:0]       value;
        logic [CNT_W-1:0] count;
        logic             fend;
    } t_cmd;

    typedef struct packed {
        logic             delta_en;
        logic [WID_W-1:0] w_eff;
    } t_back_cfg;

    typedef struct packed {
        logic             kind;
        logic [7:0]       value;
        logic             last;
        logic             fend;
        logic             delta;
        logic [COL_W-1:0] col;
    } t_tok;

endpackage
`default_nettype wire

/* src/pcx_rle_delta_decoder_core.sv */
// Top level of the PCX run-length/delta decoder: configuration registers and wiring.
//
// Bytes of the PCX payload after the header go in on the push side; pixels and then
// palette components (shifted right by two) come out on the pop side. A literal or
// raw byte becomes one command in the front end; a count byte takes no output slot,
// and its value byte expands in the back end at one result per cycle while the pop
// side keeps up, so throughput is one result per cycle, limited by the back end's
// single issue stage and the one read port of the 1024-byte line buffer. A four-entry
// command queue separates the two halves; the input reports full only when that queue
// is full. The result port is registered. No clearing pass after reset.
`default_nettype none
module pcx_rle_delta_decoder_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic [7:0]                    i_in_byte,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic [7:0]                         o_value,
    output logic                               o_kind,
    output logic                               o_last,
    output logic                               o_frame_end,
    input  wire logic                          i_cfg_we,
    input  wire logic [prd_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [prd_pkg::CFG_W-1:0]     i_cfg_wdata
);

    logic [1:0]                r_mode;
    logic [prd_pkg::WID_W-1:0] r_width;
    logic [prd_pkg::HGT_W-1:0] r_height;
    logic [prd_pkg::WID_W-1:0] w_w_eff;

    prd_pkg::t_cmd      w_f_cmd, w_q_cmd;
    logic               w_f_push, w_q_full, w_q_empty, w_q_pop;
    prd_pkg::t_back_cfg w_bcfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= prd_pkg::MODE_RESET;
            r_width  <= prd_pkg::WIDTH_RESET;
            r_height <= prd_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                prd_pkg::CFG_MODE:   r_mode   <= i_cfg_wdata[1:0];
                prd_pkg::CFG_WIDTH:  r_width  <= i_cfg_wdata[prd_pkg::WID_W-1:0];
                prd_pkg::CFG_HEIGHT: r_height <= i_cfg_wdata[prd_pkg::HGT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_w_eff = (r_width > prd_pkg::WID_W'(prd_pkg::MAX_WIDTH))
                   ? prd_pkg::WID_W'(prd_pkg::MAX_WIDTH) : r_width;

    assign w_bcfg.delta_en = r_mode == prd_pkg::MODE_DELTA;
    assign w_bcfg.w_eff    = w_w_eff;

    assign o_full = w_q_full;

    prd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_byte   (i_in_byte),
        .i_q_full (w_q_full),
        .i_mode   (r_mode),
        .i_w_eff  (w_w_eff),
        .i_height (r_height),
        .o_q_cmd  (w_f_cmd),
        .o_q_push (w_f_push)
    );

    prd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_cmd   (w_f_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_cmd   (w_q_cmd)
    );

    prd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_q_pop),
        .i_cfg       (w_bcfg),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_value     (o_value),
        .o_kind      (o_kind),
        .o_last      (o_last),
        .o_frame_end (o_frame_end)
    );

endmodule
`default_nettype wire

/* src/prd_front.sv */
// Front end: accepts payload bytes, tracks phase and pixel count, emits commands.
`default_nettype none
module prd_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire logic [7:0]                i_byte,
    input  wire logic                      i_q_full,
    input  wire logic [1:0]                i_mode,
    input  wire logic [prd_pkg::WID_W-1:0] i_w_eff,
    input  wire logic [prd_pkg::HGT_W-1:0] i_height,
    output prd_pkg::t_cmd                  o_q_cmd,
    output logic                           o_q_push
);

    prd_pkg::t_phase                r_phase, n_phase, w_ep;
    logic [prd_pkg::CNT_W-1:0]      r_run, n_run;
    logic                           r_await, n_await;
    logic [prd_pkg::PIX_W-1:0]      r_pidx, n_pidx;
    logic [prd_pkg::PAL_W-1:0]      r_pal, n_pal;

    logic                           w_acc;
    logic [prd_pkg::TOT_W-1:0]      w_total;
    logic [prd_pkg::TOT_W-1:0]      w_remain;
    logic                           w_done_in;
    logic                           w_post_done;
    logic                           w_fin;
    logic                           w_mark;
    logic [prd_pkg::CNT_W-1:0]      w_clip;
    logic [prd_pkg::CNT_W-1:0]      w_inc;
    logic [prd_pkg::PIX_W-1:0]      w_pidx_next;

    assign w_acc     = i_push && !i_q_full;
    assign w_total   = prd_pkg::TOT_W'(i_w_eff) * prd_pkg::TOT_W'(i_height);
    assign w_done_in = {1'b0, r_pidx} >= w_total;
    assign w_remain  = w_total - {1'b0, r_pidx};
    assign w_mark    = (i_byte & prd_pkg::RUN_MARK) == prd_pkg::RUN_MARK;
    assign w_clip    = (w_remain < prd_pkg::TOT_W'(r_run)) ? w_remain[prd_pkg::CNT_W-1:0]
                                                          : r_run;
    assign w_fin     = r_pal == prd_pkg::PAL_W'(prd_pkg::PAL_BYTES - 1);
    assign w_ep      = (r_phase == prd_pkg::PH_IMAGE && w_done_in) ? prd_pkg::PH_SEP
                                                                   : r_phase;

    always_comb begin
        w_inc = '0;
        if (w_ep == prd_pkg::PH_IMAGE) begin
            if (i_mode == prd_pkg::MODE_RAW) begin
                w_inc = prd_pkg::CNT_W'(1);
            end else if (r_await) begin
                w_inc = w_clip;
            end else if (!w_mark) begin
                w_inc = prd_pkg::CNT_W'(1);
            end
        end
    end

    assign w_pidx_next = r_pidx + prd_pkg::PIX_W'(w_inc);
    assign w_post_done = {1'b0, w_pidx_next} >= w_total;

    always_comb begin
        n_phase = r_phase;
        if (w_acc) begin
            unique case (w_ep)
                prd_pkg::PH_IMAGE: begin
                    if (w_post_done) n_phase = prd_pkg::PH_SEP;
                    else             n_phase = prd_pkg::PH_IMAGE;
                end
                prd_pkg::PH_SEP:  n_phase = prd_pkg::PH_PAL;
                prd_pkg::PH_PAL: begin
                    if (w_fin) n_phase = prd_pkg::PH_DONE;
                    else       n_phase = prd_pkg::PH_PAL;
                end
                prd_pkg::PH_DONE: n_phase = prd_pkg::PH_DONE;
                default:          n_phase = r_phase;
            endcase
        end
    end

    always_comb begin
        n_run         = r_run;
        n_await       = r_await;
        n_pidx        = r_pidx;
        n_pal         = r_pal;
        o_q_push      = 1'b0;
        o_q_cmd.kind  = prd_pkg::KIND_PIXEL;
        o_q_cmd.value = i_byte;
        o_q_cmd.count = w_inc;
        o_q_cmd.fend  = 1'b0;
        if (w_acc) begin
            unique case (w_ep)
                prd_pkg::PH_IMAGE: begin
                    n_pidx = w_pidx_next;
                    if (i_mode != prd_pkg::MODE_RAW && r_await) begin
                        n_await = 1'b0;
                        n_run   = '0;
                    end else if (i_mode != prd_pkg::MODE_RAW && w_mark) begin
                        n_run   = i_byte[prd_pkg::CNT_W-1:0];
                        n_await = 1'b1;
                    end
                    o_q_push = w_inc != '0;
                    if (w_post_done) begin
                        n_await = 1'b0;
                        n_run   = '0;
                    end
                end
                prd_pkg::PH_SEP: begin
                    n_pal   = '0;
                    n_await = 1'b0;
                    n_run   = '0;
                end
                prd_pkg::PH_PAL: begin
                    o_q_push      = 1'b1;
                    o_q_cmd.kind  = prd_pkg::KIND_PAL;
                    o_q_cmd.value = i_byte >> 2;
                    o_q_cmd.count = prd_pkg::CNT_W'(1);
                    o_q_cmd.fend  = w_fin;
                    n_pal         = r_pal + 1'b1;
                end
                prd_pkg::PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= prd_pkg::PH_IMAGE;
            r_run   <= '0;
            r_await <= 1'b0;
            r_pidx  <= '0;
            r_pal   <= '0;
        end else begin
            r_phase <= n_phase;
            r_run   <= n_run;
            r_await <= n_await;
            r_pidx  <= n_pidx;
            r_pal   <= n_pal;
        end
    end

endmodule
`default_nettype wire

/* src/prd_cmd_fifo.sv */
// Small command queue between the front end and the pixel back end.
`default_nettype none
module prd_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire prd_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output prd_pkg::t_cmd      o_cmd
);

    prd_pkg::t_cmd                r_mem [prd_pkg::Q_DEPTH];
    logic [prd_pkg::Q_PTR_W-1:0]  r_wr, r_rd;
    logic [prd_pkg::Q_PTR_W:0]    r_cnt;
    logic                         w_do_push, w_do_pop;

    assign o_full    = r_cnt == (prd_pkg::Q_PTR_W + 1)'(prd_pkg::Q_DEPTH);
    assign o_empty   = r_cnt == '0;
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_cmd     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) r_wr <= r_wr + 1'b1;
            if (w_do_pop)  r_rd <= r_rd + 1'b1;
            if (w_do_push && !w_do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_do_pop && !w_do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

/* src/prd_back.sv */
// Back end: expands commands into results, applies vertical delta via line buffer.
`default_nettype none
module prd_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire prd_pkg::t_cmd      i_q_cmd,
    output logic                    o_q_pop,
    input  wire prd_pkg::t_back_cfg i_cfg,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output logic [7:0]              o_value,
    output logic                    o_kind,
    output logic                    o_last,
    output logic                    o_frame_end
);

    logic [7:0]                r_line [prd_pkg::MAX_WIDTH];
    logic [prd_pkg::CNT_W-1:0] r_a_cnt;
    prd_pkg::t_cmd             r_a_cmd;
    logic [prd_pkg::COL_W-1:0] r_col;
    logic                      r_first;
    logic                      r_b_v;
    prd_pkg::t_tok             r_b_tok;
    logic [7:0]                r_rd;
    logic                      r_fwd;
    logic [7:0]                r_fwd_data;
    logic                      r_o_v;
    logic [7:0]                r_o_value;
    logic                      r_o_kind, r_o_last, r_o_fend;

    logic                      w_out_rdy, w_b_adv, w_b_free;
    logic                      w_a_act, w_a_issue, w_a_fin, w_wrap, w_b_wr;
    logic [7:0]                w_above, w_b_val;
    prd_pkg::t_tok             w_tok;

    assign w_out_rdy = !r_o_v || i_pop;
    assign w_b_adv   = r_b_v && w_out_rdy;
    assign w_b_free  = !r_b_v || w_out_rdy;
    assign w_a_act   = r_a_cnt != '0;
    assign w_a_issue = w_a_act && w_b_free;
    assign w_a_fin   = w_a_issue && r_a_cnt == prd_pkg::CNT_W'(1);
    assign o_q_pop   = !i_q_empty && (!w_a_act || w_a_fin);
    assign w_wrap    = ({1'b0, r_col} + 1'b1) >= i_cfg.w_eff;

    assign w_above = r_fwd ? r_fwd_data : r_rd;
    assign w_b_val = r_b_tok.delta ? r_b_tok.value + w_above : r_b_tok.value;
    assign w_b_wr  = w_b_adv && r_b_tok.kind == prd_pkg::KIND_PIXEL;

    always_comb begin
        w_tok.kind  = r_a_cmd.kind;
        w_tok.value = r_a_cmd.value;
        w_tok.last  = r_a_cnt == prd_pkg::CNT_W'(1);
        w_tok.fend  = r_a_cmd.fend && w_tok.last;
        w_tok.delta = i_cfg.delta_en && !r_first && r_a_cmd.kind == prd_pkg::KIND_PIXEL;
        w_tok.col   = r_col;
    end

    always_ff @(posedge i_clk) begin
        if (w_b_wr) r_line[r_b_tok.col] <= w_b_val;
        if (w_a_issue) r_rd <= r_line[r_col];
    end

    // same-column write in the issue cycle (single-pixel rows) is forwarded
    always_ff @(posedge i_clk) begin
        if (w_a_issue) begin
            r_fwd      <= w_b_wr && r_b_tok.col == r_col;
            r_fwd_data <= w_b_val;
            r_b_tok    <= w_tok;
        end
        if (o_q_pop) r_a_cmd <= i_q_cmd;
        if (w_b_adv) begin
            r_o_value <= w_b_val;
            r_o_kind  <= r_b_tok.kind;
            r_o_last  <= r_b_tok.last;
            r_o_fend  <= r_b_tok.fend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_cnt <= '0;
            r_col   <= '0;
            r_first <= 1'b1;
            r_b_v   <= 1'b0;
            r_o_v   <= 1'b0;
        end else begin
            if (o_q_pop)        r_a_cnt <= i_q_cmd.count;
            else if (w_a_issue) r_a_cnt <= r_a_cnt - 1'b1;

            if (w_a_issue && r_a_cmd.kind == prd_pkg::KIND_PIXEL) begin
                if (w_wrap) begin
                    r_col   <= '0;
                    r_first <= 1'b0;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end

            if (w_a_issue)    r_b_v <= 1'b1;
            else if (w_b_adv) r_b_v <= 1'b0;

            if (w_b_adv)    r_o_v <= 1'b1;
            else if (i_pop) r_o_v <= 1'b0;
        end
    end

    assign o_empty     = !r_o_v;
    assign o_value     = r_o_value;
    assign o_kind      = r_o_kind;
    assign o_last      = r_o_last;
    assign o_frame_end = r_o_fend;

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for pcx_rle_delta_decoder_core: directed and random byte streams.
`timescale 1ns / 1ps
module testbench;
    import prd_pkg::*;

    localparam logic [1:0] MODE_RLE       = 2'd1;
    localparam logic [1:0] MODE_RLE_PLAIN = 2'd3;
    localparam logic [7:0] COUNT_MASK     = 8'h3F;
    localparam int         SETTLE_CYCLES  = 16;

    typedef struct packed {
        logic [7:0] value;
        logic       kind;
        logic       last;
        logic       frame_end;
    } t_result;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idling;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_push      = 1'b0;
    logic [7:0]           i_in_byte   = 8'h00;
    logic                 i_pop       = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr  = CFG_MODE;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 o_full;
    logic                 o_empty;
    logic [7:0]           o_value;
    logic                 o_kind;
    logic                 o_last;
    logic                 o_frame_end;

    pcx_rle_delta_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_in_byte   (i_in_byte),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_value     (o_value),
        .o_kind      (o_kind),
        .o_last      (o_last),
        .o_frame_end (o_frame_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow registers and decoder state
    logic [1:0]       cfg_mode   = MODE_RESET;
    logic [WID_W-1:0] cfg_width  = WIDTH_RESET;
    logic [HGT_W-1:0] cfg_height = HEIGHT_RESET;
    t_phase           ph         = PH_IMAGE;
    logic [7:0]       run_len    = 8'h00;
    logic             run_armed  = 1'b0;
    int unsigned      pix_count  = 0;
    int unsigned      col        = 0;
    logic             top_row    = 1'b1;
    int unsigned      pal_count  = 0;
    int               out_cnt;
    logic [7:0]       line_buf [MAX_WIDTH] = '{default: 8'h00};

    t_result decoded_q [$];
    int      mismatches = 0;
    int      gap_pct    = 0;
    int      stall_pct  = 0;

    function automatic void put_pixel(input logic [7:0] b, input int unsigned w_eff);
        logic [7:0] v;
        v = b;
        if (col < MAX_WIDTH) begin
            if (cfg_mode == MODE_DELTA && !top_row) v = v + line_buf[col];
            line_buf[col] = v;
        end
        decoded_q.push_back('{v, KIND_PIXEL, 1'b0, 1'b0});
        out_cnt++;
        pix_count++;
        if (col + 1 >= w_eff) begin
            col = 0;
            top_row = 1'b0;
        end else begin
            col++;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int unsigned w_eff;
        int unsigned total;
        logic        fin;
        w_eff = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
        total = w_eff * int'(cfg_height);
        out_cnt = 0;
        if (ph == PH_IMAGE && pix_count >= total) begin
            ph = PH_SEP;
            run_armed = 1'b0;
            run_len = 8'h00;
        end
        case (ph)
            PH_IMAGE: begin
                if (cfg_mode == MODE_RAW) begin
                    put_pixel(b, w_eff);
                end else if (run_armed) begin
                    run_armed = 1'b0;
                    for (int k = 0; k < run_len && pix_count < total; k++)
                        put_pixel(b, w_eff);
                    run_len = 8'h00;
                end else if ((b & RUN_MARK) == RUN_MARK) begin
                    run_len = b & COUNT_MASK;
                    run_armed = 1'b1;
                end else begin
                    put_pixel(b, w_eff);
                end
                if (pix_count >= total) begin
                    ph = PH_SEP;
                    run_armed = 1'b0;
                    run_len = 8'h00;
                end
            end
            PH_SEP: begin
                ph = PH_PAL;
                pal_count = 0;
            end
            PH_PAL: begin
                fin = (pal_count + 1 >= PAL_BYTES);
                decoded_q.push_back('{b >> 2, KIND_PAL, 1'b0, fin});
                out_cnt = 1;
                pal_count++;
                if (fin) ph = PH_DONE;
            end
            default: ;
        endcase
        if (out_cnt > 0) decoded_q[decoded_q.size()-1].last = 1'b1;
    endfunction

    function automatic void flag_mismatch(input string what, input t_result want,
                                          input t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch (%s): expected value=%02h kind=%0d last=%0d frame_end=%0d, got value=%02h kind=%0d last=%0d frame_end=%0d",
                     $realtime, what, want.value, want.kind, want.last, want.frame_end,
                     got.value, got.kind, got.last, got.frame_end);
    endfunction

    // result side: random stalls, each popped transaction checked against the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                got = '{o_value, o_kind, o_last, o_frame_end};
                if (decoded_q.size() == 0) begin
                    flag_mismatch("no transaction expected", '0, got);
                end else begin
                    want = decoded_q.pop_front();
                    if (got.value !== want.value || got.kind !== want.kind ||
                        got.last !== want.last || got.frame_end !== want.frame_end)
                        flag_mismatch("field", want, got);
                end
            end
            i_pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic set_idling(input t_idling m);
        case (m)
            IDLE_NONE: begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin gap_pct = 81; stall_pct = 0;  end
            IDLE_RECV: begin gap_pct = 0;  stall_pct = 81; end
            default:   begin gap_pct = 23; stall_pct = 23; end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < gap_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_full);
        decode_byte(b);
    endtask

    task automatic wait_idle();
        i_push <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // writes all three registers; upper data bits beyond each register are random
    task automatic configure(input logic [1:0] mode, input logic [WID_W-1:0] width,
                             input logic [HGT_W-1:0] height);
        logic [CFG_W-1:0] mode_data;
        logic [CFG_W-1:0] width_data;
        mode_data = CFG_W'($urandom);
        mode_data[1:0] = mode;
        width_data = CFG_W'($urandom);
        width_data[WID_W-1:0] = width;
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_MODE;
        i_cfg_wdata <= mode_data;
        @(posedge i_clk);
        i_cfg_addr <= CFG_WIDTH;
        i_cfg_wdata <= width_data;
        @(posedge i_clk);
        i_cfg_addr <= CFG_HEIGHT;
        i_cfg_wdata <= height;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_mode = mode_data[1:0];
        cfg_width = width_data[WID_W-1:0];
        cfg_height = height;
    endtask

    // mostly well-formed runs and literals, some arbitrary bytes
    task automatic send_stream(input int steps);
        int sel;
        repeat (steps) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                send_byte(RUN_MARK | 8'($urandom_range(63)));
                send_byte(8'($urandom_range(255)));
            end else if (sel < 85) begin
                send_byte(8'($urandom_range(191)));
            end else begin
                send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_reset_values();
        set_idling(IDLE_NONE);
        send_byte(8'h00);
        send_byte(8'hBF);
        send_byte(8'h3F);
        send_byte(8'h80);
        send_byte(8'hC1);
        send_byte(8'hFF);
        send_byte(8'hC0);
        send_byte(8'h55);
        send_byte(8'hC3);
        send_byte(8'h01);
    endtask

    // one full 1024-pixel row so every line buffer entry holds a pixel
    task automatic test_line_fill();
        set_idling(IDLE_BOTH);
        configure(MODE_RLE_PLAIN, 11'd1024, 16'hFFFF);
        while (top_row) begin
            send_byte(RUN_MARK | COUNT_MASK);
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_raw_bytes();
        set_idling(IDLE_RECV);
        configure(MODE_RAW, 11'h7FF, 16'hFFFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hC0);
        send_byte(8'hFE);
        send_byte(8'h3F);
        send_byte(8'h01);
    endtask

    // a count byte stays armed across register writes
    task automatic test_pending_run();
        set_idling(IDLE_SEND);
        configure(MODE_RLE, 11'd5, 16'hFFFF);
        send_byte(8'hFF);
        configure(MODE_DELTA, 11'd7, 16'hFFFF);
        send_byte(8'hAA);
        send_byte(8'hC4);
        configure(MODE_RAW, 11'd7, 16'hFFFF);
        send_byte(8'h12);
        configure(MODE_DELTA, 11'd7, 16'hFFFF);
        send_byte(8'h34);
    endtask

    task automatic test_width_one();
        set_idling(IDLE_NONE);
        configure(MODE_DELTA, 11'd1, 16'hFFFF);
        send_byte(8'h7F);
        send_byte(8'h81);
        send_byte(8'hC2);
        send_byte(8'hF0);
    endtask

    task automatic test_random_streams();
        logic [1:0]       mode;
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
        int unsigned      w_eff;
        int unsigned      floor_h;
        for (int p = 0; p < 14; p++) begin
            set_idling(t_idling'(p % 4));
            mode = 2'($urandom_range(3));
            case ($urandom_range(9))
                0:       width = 11'd1024;
                1:       width = 11'h7FF;
                2:       width = 11'd1;
                3:       width = 11'($urandom_range(2047, 1025));
                default: width = 11'($urandom_range(40, 2));
            endcase
            w_eff = (width > MAX_WIDTH) ? MAX_WIDTH : int'(width);
            floor_h = (pix_count + 3000) / w_eff + 1;
            if (floor_h > 65535 || $urandom_range(1) == 0)
                height = 16'hFFFF;
            else
                height = 16'($urandom_range(65535, floor_h));
            configure(mode, width, height);
            send_stream(18);
        end
    endtask

    // total set just past the current count, so a long run gets cut short
    task automatic test_run_clipped();
        set_idling(IDLE_BOTH);
        configure(MODE_RLE, 11'd8, 16'hFFFF);
        if (run_armed) send_byte(8'h01);
        configure(MODE_RLE, 11'd8, 16'(pix_count / 8 + 1));
        send_byte(RUN_MARK | COUNT_MASK);
        send_byte(8'($urandom_range(255)));
    endtask

    task automatic test_palette();
        logic [7:0] b;
        send_byte(8'($urandom_range(255)));
        for (int p = 0; p < 4; p++) begin
            set_idling(t_idling'(p));
            for (int i = 0; i < PAL_BYTES / 4; i++) begin
                if (p == 0 && i == 0)      b = 8'h00;
                else if (p == 0 && i == 1) b = 8'hFF;
                else                       b = 8'($urandom_range(255));
                send_byte(b);
            end
        end
        // bytes after the palette produce nothing
        repeat (5) send_byte(8'($urandom_range(255)));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_line_fill();
        test_raw_bytes();
        test_pending_run();
        test_width_one();
        test_random_streams();
        test_run_clipped();
        test_palette();
        wait_idle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #16_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
